[design/rfd_pkg.sv]
// Shared constants, types and keyword tables for the reply frame deframer.
`default_nettype none
package rfd_pkg;

  // Frame markers
  localparam logic [7:0] START_MARK = 8'd253;
  localparam logic [7:0] END_MARK   = 8'd254;

  // Minimum text length that is emitted character by character
  localparam logic [7:0] MIN_LISTED = 8'd3;

  // Keyword codes
  localparam int unsigned NUM_KEYS = 6;
  localparam int unsigned KEY_MAX  = 9;
  localparam logic [2:0] KW_NONE      = 3'd0;
  localparam logic [2:0] KW_DONE      = 3'd1;
  localparam logic [2:0] KW_READY     = 3'd2;
  localparam logic [2:0] KW_WRK       = 3'd3;
  localparam logic [2:0] KW_WAIT      = 3'd4;
  localparam logic [2:0] KW_PRN       = 3'd5;
  localparam logic [2:0] KW_SOFTBLOCK = 3'd6;

  // Keyword lengths, in code order
  localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{4'd4, 4'd5, 4'd3, 4'd4, 4'd3, 4'd9};

  // Keyword characters, padded with zeros
  localparam logic [7:0] KEY_CHARS [NUM_KEYS][KEY_MAX] = '{
    '{"D", "O", "N", "E", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"R", "E", "A", "D", "Y", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"W", "R", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"W", "A", "I", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "R", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "O", "F", "T", "B", "L", "O", "C", "K"}
  };

  // Control from the sequencer to the keyword matcher
  typedef struct packed {
    logic clear;
    logic en;
  } kwm_ctrl_t;

endpackage
`default_nettype wire

[design/rfd_store.sv]
// Frame store: single-port-write, registered-read byte memory.
`default_nettype none
module rfd_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  // Write a byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read a byte, hold the data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[design/rfd_kwmatch.sv]
// Incremental keyword matcher: compares text one character at a time.
`default_nettype none
module rfd_kwmatch #(
  parameter int CW = 7
) (
  input  wire logic              clk,
  input  wire rfd_pkg::kwm_ctrl_t ctrl,
  input  wire logic [CW-1:0]     idx,
  input  wire logic [7:0]        char_in,
  input  wire logic [CW-1:0]     text_len,
  output logic      [2:0]        kw
);

  logic [rfd_pkg::NUM_KEYS-1:0] hit_r;
  logic [rfd_pkg::NUM_KEYS-1:0] hit_nxt;

  // Drop a keyword once a character within its length differs
  always_comb begin
    hit_nxt = hit_r;
    if (ctrl.clear) begin
      hit_nxt = '1;
    end else if (ctrl.en) begin
      for (int k = 0; k < rfd_pkg::NUM_KEYS; k++) begin
        if (8'(idx) < 8'(rfd_pkg::KEY_LEN[k])) begin
          if (char_in != rfd_pkg::KEY_CHARS[k][idx[3:0]]) begin
            hit_nxt[k] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
  end

  // Pick the first keyword whose length equals the text length
  always_comb begin
    kw = rfd_pkg::KW_NONE;
    for (int k = rfd_pkg::NUM_KEYS - 1; k >= 0; k--) begin
      if (hit_r[k] && (8'(text_len) == 8'(rfd_pkg::KEY_LEN[k]))) begin
        kw = 3'(k + 1);
      end
    end
  end

endmodule
`default_nettype wire

[design/reply_frame_deframer_core.sv]
// Top level of the reply frame deframer: byte intake, frame scan and text emission.
// Takes one word per cycle while idle; a data byte or a send event keeps it idle. The
// end marker of a frame starts a scan of the frame store (a read state and a check state per
// text character, as the store read is registered), a keyword decision state, then
// emission through a read state and a load state per character (or one empty result), after
// which words are taken again, so a frame holds the input for its whole scan and emission plus
// any output stall. The result register lets the next input word be taken while the last
// result still waits. The CRC bytes are skipped and not checked; the CRC setting is
// sampled when the end marker arrives.
`default_nettype none
module reply_frame_deframer_core #(
  parameter int FRAME_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  in_tuser,   // [0] opcode, [1] first_in_read
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [7:0] text_char, [10:8] keyword,
                                       // [16:11] status_flags, [17] command_listed
  output logic             out_tuser,  // [0] text_valid
  output logic             out_tlast,  // last_of_frame
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data    // crc_enabled
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam logic [7:0] LEN_MAX = 8'(FRAME_BYTES - 2);

  typedef enum logic [2:0] {
    S_IDLE, S_SRD, S_SCHK, S_KW, S_ERD, S_ELOAD, S_EMPTY
  } state_t;

  state_t state_r, state_nxt;

  logic          crc_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic          parse_r, parse_nxt;
  logic          aep_r, aep_nxt;
  logic          skip_r, skip_nxt;
  logic [5:0]    sticky_r, sticky_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [2:0]    kw_r, kw_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic          out_tv_r, out_tv_nxt;
  logic          out_last_r, out_last_nxt;
  logic [2:0]    out_kw_r, out_kw_nxt;
  logic [5:0]    out_status_r, out_status_nxt;
  logic          out_listed_r, out_listed_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  rfd_pkg::kwm_ctrl_t kwm_ctrl;
  logic [2:0]         kw_match;

  logic          in_acc;
  logic          op;
  logic          first;
  logic [7:0]    b;
  logic          out_free;

  // Per-word working values
  logic          pe_w, aep_w, skip_w;
  logic [CW-1:0] cnt_w;
  logic [7:0]    prev_w;
  logic [7:0]    len_byte;
  logic [7:0]    len_raw;
  logic [CW-1:0] cnt_inc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign op        = in_tuser[0];
  assign first     = in_tuser[1];
  assign b         = in_tdata;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  rfd_store #(.DEPTH(FRAME_BYTES), .AW(AW)) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (b),
    .re      (re),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  rfd_kwmatch #(.CW(CW)) u_kwmatch (
    .clk      (clk),
    .ctrl     (kwm_ctrl),
    .idx      (n_r),
    .char_in  (rdata),
    .text_len (n_r),
    .kw       (kw_match)
  );

  // Sequence intake, scan and emission
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    prev_nxt       = prev_r;
    parse_nxt      = parse_r;
    aep_nxt        = aep_r;
    skip_nxt       = skip_r;
    sticky_nxt     = sticky_r;
    len_nxt        = len_r;
    fill_nxt       = fill_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    kw_nxt         = kw_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_char_nxt   = out_char_r;
    out_tv_nxt     = out_tv_r;
    out_last_nxt   = out_last_r;
    out_kw_nxt     = out_kw_r;
    out_status_nxt = out_status_r;
    out_listed_nxt = out_listed_r;
    we             = 1'b0;
    waddr          = cnt_r[AW-1:0];
    re             = 1'b0;
    raddr          = AW'(n_r + 1'b1);
    kwm_ctrl       = '{clear: 1'b0, en: 1'b0};

    pe_w     = first ? (b == rfd_pkg::START_MARK) : parse_r;
    cnt_w    = first ? '0 : cnt_r;
    prev_w   = first ? '0 : prev_r;
    aep_w    = first ? 1'b0 : aep_r;
    skip_w   = first ? 1'b0 : skip_r;
    len_byte = (cnt_w != '0) ? prev_w : 8'd0;
    len_raw  = (len_byte != 8'd0) ? (len_byte - 8'd1) : 8'd0;
    cnt_inc  = (cnt_w < CW'(FRAME_BYTES)) ? (cnt_w + 1'b1) : cnt_w;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (op) begin
            // Send event: clear the status flags only
            sticky_nxt = '0;
          end else begin
            parse_nxt = pe_w;
            cnt_nxt   = cnt_w;
            prev_nxt  = prev_w;
            aep_nxt   = aep_w;
            skip_nxt  = skip_w;
            if (pe_w) begin
              if (skip_w) begin
                skip_nxt = 1'b0;
              end else if (aep_w && (b != rfd_pkg::START_MARK)) begin
                aep_nxt  = 1'b0;
                skip_nxt = 1'b1;
              end else begin
                // Store the byte while there is room
                aep_nxt  = 1'b0;
                we       = (cnt_w < CW'(FRAME_BYTES));
                waddr    = cnt_w[AW-1:0];
                cnt_nxt  = cnt_inc;
                prev_nxt = b;
                if (b == rfd_pkg::END_MARK) begin
                  len_nxt   = (len_raw > LEN_MAX) ? CW'(LEN_MAX) : CW'(len_raw);
                  fill_nxt  = cnt_inc;
                  n_nxt     = '0;
                  kwm_ctrl  = '{clear: 1'b1, en: 1'b0};
                  cnt_nxt   = '0;
                  prev_nxt  = '0;
                  aep_nxt   = crc_r;
                  state_nxt = S_SRD;
                end
              end
            end
          end
        end
      end
      S_SRD: begin
        // Read the next text character, or stop at the length or the fill
        if ((n_r < len_r) && ((n_r + 1'b1) < fill_r)) begin
          re        = 1'b1;
          state_nxt = S_SCHK;
        end else begin
          state_nxt = S_KW;
        end
      end
      S_SCHK: begin
        if (rdata == 8'd0) begin
          state_nxt = S_KW;
        end else begin
          kwm_ctrl  = '{clear: 1'b0, en: 1'b1};
          n_nxt     = n_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_KW: begin
        // Decide the keyword and update the flags
        kw_nxt = kw_match;
        if (kw_match != rfd_pkg::KW_NONE) begin
          sticky_nxt = sticky_r | (6'd1 << (kw_match - 3'd1));
        end
        i_nxt = '0;
        if (8'(n_r) >= rfd_pkg::MIN_LISTED) begin
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_EMPTY;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = 8'd0;
          out_tv_nxt     = 1'b0;
          out_last_nxt   = 1'b1;
          out_kw_nxt     = kw_r;
          out_status_nxt = sticky_r;
          out_listed_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_ERD: begin
        re        = 1'b1;
        raddr     = AW'(i_r + 1'b1);
        state_nxt = S_ELOAD;
      end
      S_ELOAD: begin
        // Load one character into the result register
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = rdata;
          out_tv_nxt     = 1'b1;
          out_last_nxt   = ((i_r + 1'b1) == n_r);
          out_kw_nxt     = kw_r;
          out_status_nxt = sticky_r;
          out_listed_nxt = 1'b1;
          i_nxt          = i_r + 1'b1;
          state_nxt      = ((i_r + 1'b1) == n_r) ? S_IDLE : S_ERD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      crc_r       <= 1'b0;
      cnt_r       <= '0;
      prev_r      <= '0;
      parse_r     <= 1'b0;
      aep_r       <= 1'b0;
      skip_r      <= 1'b0;
      sticky_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        crc_r <= cfg_data;
      end
      cnt_r       <= cnt_nxt;
      prev_r      <= prev_nxt;
      parse_r     <= parse_nxt;
      aep_r       <= aep_nxt;
      skip_r      <= skip_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Advance the payload registers
  always_ff @(posedge clk) begin
    len_r        <= len_nxt;
    fill_r       <= fill_nxt;
    n_r          <= n_nxt;
    i_r          <= i_nxt;
    kw_r         <= kw_nxt;
    out_char_r   <= out_char_nxt;
    out_tv_r     <= out_tv_nxt;
    out_last_r   <= out_last_nxt;
    out_kw_r     <= out_kw_nxt;
    out_status_r <= out_status_nxt;
    out_listed_r <= out_listed_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_listed_r, out_status_r, out_kw_r, out_char_r};
  assign out_tuser  = out_tv_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
